// ===== design/wimp_pkg.sv =====
// shared constants, types and helpers of the wire image max pool downsampler
`default_nettype none

package wimp_pkg;

  // line buffer depth and derived address width
  localparam int unsigned MAX_OUT_BINS = 1024;
  localparam int unsigned BIN_W        = (MAX_OUT_BINS > 1) ? $clog2(MAX_OUT_BINS) : 1;

  // field widths
  localparam int unsigned SCALE_W   = 7;
  localparam int unsigned PHASE_W   = 6;
  localparam int unsigned SIZE_W    = 14;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MAG_W     = 15;
  localparam int unsigned ROW_W     = 14;
  localparam int unsigned OUT_BIN_W = 10;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // reset values of the configuration registers
  localparam logic [SCALE_W-1:0] SCALE_X_RST     = 7'd10;
  localparam logic [SCALE_W-1:0] SCALE_Y_RST     = 7'd10;
  localparam logic [SIZE_W-1:0]  NUM_SAMPLES_RST = 14'd9600;
  localparam logic [SIZE_W-1:0]  NUM_WIRES_RST   = 14'd8256;

  // largest usable scale
  localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd64;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X     = 2'd0,
    CFG_SCALE_Y     = 2'd1,
    CFG_NUM_SAMPLES = 2'd2,
    CFG_NUM_WIRES   = 2'd3
  } cfg_reg_e;

  // one classified sample, handed from front to back
  typedef struct packed {
    logic [BIN_W-1:0]           bin;
    logic [ROW_W-1:0]           row;
    logic signed [SAMPLE_W-1:0] signal_sample;
    logic signed [SAMPLE_W-1:0] noise_sample;
    logic                       noise_ok;
    logic                       good;
    logic                       block_start;
    logic                       emit;
    logic                       last;
  } wimp_op_t;

  // a scale of 0 acts as 1, above 64 acts as 64
  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    if (v == '0) begin
      r = SCALE_W'(1);
    end else if (v > SCALE_MAX) begin
      r = SCALE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // a size of 0 acts as 1
  function automatic logic [SIZE_W-1:0] at_least_one(input logic [SIZE_W-1:0] v);
    return (v == '0) ? SIZE_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

// ===== design/wimp_if.sv =====
// channel interfaces: sample input, result output and configuration writes
`default_nettype none

interface wimp_in_if;
  import wimp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] signal_sample;
  logic signed [SAMPLE_W-1:0] noise_sample;
  logic                       noise_present;
  logic                       channel_good;

  modport source (output valid, signal_sample, noise_sample, noise_present, channel_good,
                  input ready);
  modport sink   (input valid, signal_sample, noise_sample, noise_present, channel_good,
                  output ready);
endinterface

interface wimp_out_if;
  import wimp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_BIN_W-1:0] out_bin;
  logic [MAG_W-1:0]     max_signal;
  logic [MAG_W-1:0]     max_noise;
  logic                 last;

  modport source (output valid, out_row, out_bin, max_signal, max_noise, last, input ready);
  modport sink   (input valid, out_row, out_bin, max_signal, max_noise, last, output ready);
endinterface

interface wimp_cfg_if;
  import wimp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/wire_image_max_pool_downsample_unit.sv =====
// top level of the wire image max pool downsampler
//
// Usage: samples enter on in_i wire by wire, tick by tick, one transaction per
// sample; results leave on out_o, one per finished bin on the last wire of each
// group of scale_y wires. cfg_i writes scale_x, scale_y, num_samples, num_wires
// (index 0..3); any write restarts the image. Write only while the block is idle.
// Throughput: one sample per cycle unless the receiver stalls. The line buffer
// is a single-port read, single-port write memory; a read-modify-write per
// sample is bypassed when two back-to-back samples hit the same bin.
// Path: the sample completing a bin passes the queue and the read stage; the
// result register then holds its result until out_o takes it.
// Samples outside full groups are dropped in the front and yield nothing.
// Reset: registers return to 10, 10, 9600, 8256 and the counters clear; no
// clearing pass over the line buffer is needed, since the first sample of every
// block starts from zero instead of the stored value. Ready is high after reset.
// Receiver stall: samples that emit nothing keep flowing; an emitting sample
// waits in the read stage, the 4-entry queue fills and then in_i.ready drops.
`default_nettype none

module wire_image_max_pool_downsample_unit
  import wimp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wimp_in_if.sink    in_i,
  wimp_cfg_if.sink   cfg_i,
  wimp_out_if.source out_o
);

  wimp_op_t front_op, q_op;
  logic     front_valid, q_ready, q_valid, back_ready;

  // classification
  wimp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .op_o       (front_op),
    .op_valid_o (front_valid),
    .op_ready_i (q_ready)
  );

  // decoupling queue
  wimp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_data_i  (front_op),
    .push_ready_o (q_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_op),
    .pop_ready_i  (back_ready)
  );

  // pooling datapath
  wimp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_op),
    .op_ready_o (back_ready),
    .out_o      (out_o)
  );

  // input is stalled exactly when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_i.ready == q_ready)
    else $error("input ready does not follow queue space");

  // a queued item stays queued until the back end takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (q_valid && !back_ready && !front_valid) |=> q_valid)
    else $error("queued item lost without being taken");

  // an emitting sample taken by the back end never overwrites a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && !out_o.ready) |=>
                   (out_o.valid && $stable(out_o.out_row) && $stable(out_o.max_signal)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== design/wimp_front.sv =====
// front end: configuration registers, image position counters and sample classification
`default_nettype none

module wimp_front
  import wimp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wimp_in_if.sink    in_i,
  wimp_cfg_if.sink   cfg_i,
  output wimp_op_t   op_o,
  output logic       op_valid_o,
  input  wire logic  op_ready_i
);

  logic [SCALE_W-1:0] scale_x_q, scale_y_q;
  logic [SIZE_W-1:0]  num_samples_q, num_wires_q;
  logic [SIZE_W-1:0]  tick_q, wire_q, bin_idx_q, bin_base_q, row_idx_q, row_base_q;
  logic [PHASE_W-1:0] bin_phase_q, row_phase_q;

  logic [SCALE_W-1:0] sx, sy;
  logic [SIZE_W-1:0]  ns, nw;
  logic [SIZE_W+1:0]  bin_end, row_end;
  logic               bin_full, bin_in_range, bin_last, row_full, row_last;
  logic               bin_phase_end, row_phase_end, tick_end, wire_end;
  logic               active, accept, cfg_we;

  // effective geometry
  assign sx = clamp_scale(scale_x_q);
  assign sy = clamp_scale(scale_y_q);
  assign ns = at_least_one(num_samples_q);
  assign nw = at_least_one(num_wires_q);

  // a bin or row counts only if it is complete
  assign bin_end      = {2'b00, bin_base_q} + (SIZE_W+2)'(sx);
  assign row_end      = {2'b00, row_base_q} + (SIZE_W+2)'(sy);
  assign bin_full     = bin_end <= (SIZE_W+2)'(ns);
  assign row_full     = row_end <= (SIZE_W+2)'(nw);
  assign bin_in_range = bin_full && (bin_idx_q < SIZE_W'(MAX_OUT_BINS));
  assign bin_last     = (bin_end + (SIZE_W+2)'(sx) > (SIZE_W+2)'(ns)) ||
                        (bin_idx_q == SIZE_W'(MAX_OUT_BINS - 1));
  assign row_last     = row_end + (SIZE_W+2)'(sy) > (SIZE_W+2)'(nw);

  // end-of-period flags
  assign bin_phase_end = {1'b0, bin_phase_q} == (sx - SCALE_W'(1));
  assign row_phase_end = {1'b0, row_phase_q} == (sy - SCALE_W'(1));
  assign tick_end      = tick_q == (ns - SIZE_W'(1));
  assign wire_end      = wire_q == (nw - SIZE_W'(1));

  // classification of the current sample
  assign active = bin_in_range && row_full;

  always_comb begin
    op_o.bin           = BIN_W'(bin_idx_q);
    op_o.row           = row_idx_q;
    op_o.signal_sample = in_i.signal_sample;
    op_o.noise_sample  = in_i.noise_sample;
    op_o.noise_ok      = in_i.noise_present;
    op_o.good          = in_i.channel_good;
    op_o.block_start   = (row_phase_q == '0) && (bin_phase_q == '0);
    op_o.emit          = row_phase_end && bin_phase_end;
    op_o.last          = row_last && bin_last;
  end

  // samples outside full groups are taken and dropped here
  assign op_valid_o  = in_i.valid && active;
  assign in_i.ready  = op_ready_i;
  assign accept      = in_i.valid && op_ready_i;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  // registers and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q     <= SCALE_X_RST;
      scale_y_q     <= SCALE_Y_RST;
      num_samples_q <= NUM_SAMPLES_RST;
      num_wires_q   <= NUM_WIRES_RST;
      tick_q        <= '0;
      wire_q        <= '0;
      bin_idx_q     <= '0;
      bin_base_q    <= '0;
      row_idx_q     <= '0;
      row_base_q    <= '0;
      bin_phase_q   <= '0;
      row_phase_q   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_SCALE_X:     scale_x_q     <= cfg_i.data[SCALE_W-1:0];
        CFG_SCALE_Y:     scale_y_q     <= cfg_i.data[SCALE_W-1:0];
        CFG_NUM_SAMPLES: num_samples_q <= cfg_i.data[SIZE_W-1:0];
        CFG_NUM_WIRES:   num_wires_q   <= cfg_i.data[SIZE_W-1:0];
        default:         scale_x_q     <= scale_x_q;
      endcase
      tick_q      <= '0;
      wire_q      <= '0;
      bin_idx_q   <= '0;
      bin_base_q  <= '0;
      row_idx_q   <= '0;
      row_base_q  <= '0;
      bin_phase_q <= '0;
      row_phase_q <= '0;
    end else if (accept) begin
      if (tick_end) begin
        tick_q      <= '0;
        bin_idx_q   <= '0;
        bin_base_q  <= '0;
        bin_phase_q <= '0;
        if (wire_end) begin
          wire_q      <= '0;
          row_idx_q   <= '0;
          row_base_q  <= '0;
          row_phase_q <= '0;
        end else begin
          wire_q <= wire_q + SIZE_W'(1);
          if (row_phase_end) begin
            row_phase_q <= '0;
            row_idx_q   <= row_idx_q + SIZE_W'(1);
            row_base_q  <= wire_q + SIZE_W'(1);
          end else begin
            row_phase_q <= row_phase_q + PHASE_W'(1);
          end
        end
      end else begin
        tick_q <= tick_q + SIZE_W'(1);
        if (bin_phase_end) begin
          bin_phase_q <= '0;
          bin_idx_q   <= bin_idx_q + SIZE_W'(1);
          bin_base_q  <= tick_q + SIZE_W'(1);
        end else begin
          bin_phase_q <= bin_phase_q + PHASE_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/wimp_fifo.sv =====
// short queue of classified samples between front and back
`default_nettype none

module wimp_fifo
  import wimp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  input  wimp_op_t       push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output wimp_op_t       pop_data_o,
  input  wire logic      pop_ready_i
);

  wimp_op_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  push, pop;

  assign push_ready_o = count_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/wimp_back.sv =====
// back end: per-bin maximum line buffer, read-modify-write with forwarding, result register
`default_nettype none

module wimp_back
  import wimp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   op_valid_i,
  input  wimp_op_t    op_i,
  output logic        op_ready_o,
  wimp_out_if.source  out_o
);

  logic [2*MAG_W-1:0] line_mem [MAX_OUT_BINS];

  logic               s1_valid_q;
  wimp_op_t           s1_op_q;
  logic [2*MAG_W-1:0] rdata_q;
  logic               fwd_q;
  logic [2*MAG_W-1:0] fwd_data_q;

  logic               out_valid_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [OUT_BIN_W-1:0] out_bin_q;
  logic [MAG_W-1:0]   max_signal_q, max_noise_q, new_sig, new_noi, old_sig, old_noi;
  logic               out_last_q;

  logic               out_free, s1_fire, s1_load, pop;
  logic [2*MAG_W-1:0] old_word, wr_data;

  // stage control
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && (!s1_op_q.emit || out_free);
  assign s1_load    = !s1_valid_q || s1_fire;
  assign pop        = op_valid_i && s1_load;
  assign op_ready_o = s1_load;

  // old maxima: zero on the first sample of a block, else memory or the write just made
  always_comb begin
    old_word = fwd_q ? fwd_data_q : rdata_q;
    if (s1_op_q.block_start) begin
      old_word = '0;
    end
    old_sig = old_word[2*MAG_W-1:MAG_W];
    old_noi = old_word[MAG_W-1:0];
  end

  // running maxima
  always_comb begin
    new_sig = old_sig;
    new_noi = old_noi;
    if (s1_op_q.good && (s1_op_q.signal_sample > $signed({1'b0, old_sig}))) begin
      new_sig = s1_op_q.signal_sample[MAG_W-1:0];
    end
    if (s1_op_q.good && s1_op_q.noise_ok &&
        (s1_op_q.noise_sample > $signed({1'b0, old_noi}))) begin
      new_noi = s1_op_q.noise_sample[MAG_W-1:0];
    end
    wr_data = s1_op_q.emit ? '0 : {new_sig, new_noi};
  end

  // line buffer
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_op_q.bin] <= wr_data;
    end
    if (pop) begin
      rdata_q <= line_mem[op_i.bin];
    end
  end

  // stage payload and forwarding
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_op_q    <= op_i;
      fwd_q      <= s1_fire && (s1_op_q.bin == op_i.bin);
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= op_valid_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_op_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_op_q.emit) begin
      out_row_q    <= s1_op_q.row;
      out_bin_q    <= OUT_BIN_W'(s1_op_q.bin);
      max_signal_q <= new_sig;
      max_noise_q  <= new_noi;
      out_last_q   <= s1_op_q.last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_row    = out_row_q;
  assign out_o.out_bin    = out_bin_q;
  assign out_o.max_signal = max_signal_q;
  assign out_o.max_noise  = max_noise_q;
  assign out_o.last       = out_last_q;

endmodule

`default_nettype wire

// ===== bench/wire_image_max_pool_downsample_unit_test.sv =====
// self-checking bench for the wire image max pool downsampler
`timescale 1ns / 100ps

module wire_image_max_pool_downsample_unit_test;
  import wimp_pkg::*;

  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned RESET_CYCLES    = 12;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] signal_sample;
    logic signed [SAMPLE_W-1:0] noise_sample;
    logic                       noise_present;
    logic                       channel_good;
  } wire_sample_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_BIN_W-1:0] bin;
    logic [MAG_W-1:0]     max_signal;
    logic [MAG_W-1:0]     max_noise;
    logic                 last;
  } pool_peak_t;

  logic clk = 1'b0;
  logic rst_n;

  wimp_in_if  in_bus ();
  wimp_out_if out_bus ();
  wimp_cfg_if cfg_bus ();

  wire_image_max_pool_downsample_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pooling state mirrored by the bench
  logic [SCALE_W-1:0] scale_x_q, scale_y_q;
  logic [SIZE_W-1:0]  num_samples_q, num_wires_q;
  logic [MAG_W-1:0]   signal_peak [MAX_OUT_BINS];
  logic [MAG_W-1:0]   noise_peak [MAX_OUT_BINS];
  int unsigned        tick_cnt, wire_cnt, bin_phase, row_phase;

  wire_sample_t sample_backlog[$];
  pool_peak_t   due_peaks[$];
  wire_sample_t offered;

  int unsigned src_gap_pct, sink_stall_pct;
  bit          hold_off_armed;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned fail_count, samples_taken, results_checked, settings_run;

  // scale register as the block uses it
  function automatic int unsigned eff_scale(logic [SCALE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > int'(SCALE_MAX)) return int'(SCALE_MAX);
    return v;
  endfunction

  // size register as the block uses it
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v);
    return (v == '0) ? 1 : v;
  endfunction

  // image restart: empty line buffers, counters back to the origin
  function automatic void restart_pool();
    foreach (signal_peak[i]) begin
      signal_peak[i] = '0;
      noise_peak[i]  = '0;
    end
    tick_cnt  = 0;
    wire_cnt  = 0;
    bin_phase = 0;
    row_phase = 0;
  endfunction

  // fold one sample into the running bin maxima, queue the finished bin if due
  function automatic void fold_sample(wire_sample_t s);
    int unsigned sx, sy, ns, nw, bin_lim, rows_full, bin, row;
    int          sig_v, noise_v;
    pool_peak_t  res;
    sx        = eff_scale(scale_x_q);
    sy        = eff_scale(scale_y_q);
    ns        = eff_size(num_samples_q);
    nw        = eff_size(num_wires_q);
    bin_lim   = ns / sx;
    if (bin_lim > MAX_OUT_BINS) bin_lim = MAX_OUT_BINS;
    rows_full = nw / sy;
    bin       = tick_cnt / sx;
    row       = wire_cnt / sy;
    sig_v     = $signed(s.signal_sample);
    noise_v   = $signed(s.noise_sample);

    if (row < rows_full && bin < bin_lim) begin
      if (s.channel_good) begin
        if (sig_v > int'(signal_peak[bin])) signal_peak[bin] = MAG_W'(sig_v);
        if (s.noise_present && noise_v > int'(noise_peak[bin])) begin
          noise_peak[bin] = MAG_W'(noise_v);
        end
      end
      // last wire of the row group and last tick of the bin
      if (row_phase == sy - 1 && bin_phase == sx - 1) begin
        res.row        = ROW_W'(row);
        res.bin        = OUT_BIN_W'(bin);
        res.max_signal = signal_peak[bin];
        res.max_noise  = noise_peak[bin];
        res.last       = (row == rows_full - 1) && (bin == bin_lim - 1);
        due_peaks      = {due_peaks, res};
        signal_peak[bin] = '0;
        noise_peak[bin]  = '0;
      end
    end

    // advance tick, wire and phase counters, wrap at image end
    tick_cnt++;
    bin_phase++;
    if (bin_phase >= sx) bin_phase = 0;
    if (tick_cnt >= ns) begin
      tick_cnt  = 0;
      bin_phase = 0;
      wire_cnt++;
      row_phase++;
      if (row_phase >= sy) row_phase = 0;
      if (wire_cnt >= nw) begin
        wire_cnt  = 0;
        row_phase = 0;
      end
    end
  endfunction

  // value mix weighted toward the extremes
  function automatic logic signed [SAMPLE_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return -16'sd1;
      4:       return SAMPLE_W'($urandom_range(0, 300));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic wire_sample_t random_sample();
    wire_sample_t s;
    s.signal_sample = pick_level();
    s.noise_sample  = pick_level();
    s.noise_present = ($urandom_range(0, 3) != 0);
    s.channel_good  = ($urandom_range(0, 6) != 0);
    return s;
  endfunction

  function automatic void queue_sample(logic signed [SAMPLE_W-1:0] sig,
                                       logic signed [SAMPLE_W-1:0] noise,
                                       logic present, logic good);
    wire_sample_t s;
    s.signal_sample = sig;
    s.noise_sample  = noise;
    s.noise_present = present;
    s.channel_good  = good;
    sample_backlog  = {sample_backlog, s};
  endfunction

  function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      fail_count++;
    end
  endfunction

  // one register write transaction, then mirror it
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_SCALE_X:     scale_x_q     = value[SCALE_W-1:0];
      CFG_SCALE_Y:     scale_y_q     = value[SCALE_W-1:0];
      CFG_NUM_SAMPLES: num_samples_q = value[SIZE_W-1:0];
      CFG_NUM_WIRES:   num_wires_q   = value[SIZE_W-1:0];
      default: ;
    endcase
    restart_pool();
  endtask

  task automatic program_pool(logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy,
                              logic [CFG_DATA_W-1:0] ns, logic [CFG_DATA_W-1:0] nw);
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Y, sy);
    write_reg(CFG_NUM_SAMPLES, ns);
    write_reg(CFG_NUM_WIRES, nw);
    settings_run++;
    @(negedge clk);
  endtask

  // wait for every sample taken, every result seen, and the pipeline empty
  task automatic settle();
    while (sample_backlog.size() != 0 || in_bus.valid) @(negedge clk);
    while (due_peaks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy,
                           logic [CFG_DATA_W-1:0] ns, logic [CFG_DATA_W-1:0] nw,
                           int unsigned count, idle_mode_e mode, bit squeeze);
    program_pool(sx, sy, ns, nw);
    case (mode)
      IDLE_SENDER:   begin src_gap_pct = 55; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_gap_pct = 0;  sink_stall_pct = 55; end
      IDLE_BOTH:     begin src_gap_pct = 25; sink_stall_pct = 25; end
      default:       begin src_gap_pct = 0;  sink_stall_pct = 0;  end
    endcase
    if (squeeze) hold_off_armed = 1'b1;
    repeat (count) sample_backlog = {sample_backlog, random_sample()};
    settle();
  endtask

  // sample driver: one transaction per accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        fold_sample(offered);
        samples_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
          offered                = sample_backlog.pop_front();
          in_bus.valid          <= 1'b1;
          in_bus.signal_sample  <= offered.signal_sample;
          in_bus.noise_sample   <= offered.noise_sample;
          in_bus.noise_present  <= offered.noise_present;
          in_bus.channel_good   <= offered.channel_good;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles here
  always @(posedge clk) begin
    if (hold_off_armed) begin
      hold_off_armed = 1'b0;
      hold_left     <= HOLD_OFF_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    pool_peak_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (due_peaks.size() == 0) begin
          $error("result with none due: row %0d bin %0d", out_bus.out_row, out_bus.out_bin);
          fail_count++;
        end else begin
          want = due_peaks.pop_front();
          check_field("out_row", want.row, out_bus.out_row);
          check_field("out_bin", want.bin, out_bus.out_bin);
          check_field("max_signal", want.max_signal, out_bus.max_signal);
          check_field("max_noise", want.max_noise, out_bus.max_noise);
          check_field("last", want.last, out_bus.last);
          results_checked++;
        end
      end
      // hold off while the long stretch runs, else random stalls
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.signal_sample  = '0;
    in_bus.noise_sample   = '0;
    in_bus.noise_present  = 1'b0;
    in_bus.channel_good   = 1'b0;
    out_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_SCALE_X;
    cfg_bus.data          = '0;
    src_gap_pct           = 0;
    sink_stall_pct        = 0;
    hold_off_armed        = 1'b0;
    hold_left             = 0;
    quiet_cycles          = 0;
    fail_count            = 0;
    samples_taken         = 0;
    results_checked       = 0;
    settings_run          = 0;
    scale_x_q             = SCALE_X_RST;
    scale_y_q             = SCALE_Y_RST;
    num_samples_q         = NUM_SAMPLES_RST;
    num_wires_q           = NUM_WIRES_RST;
    restart_pool();

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // a few samples under the reset settings, nothing due yet
    repeat (3) sample_backlog = {sample_backlog, random_sample()};
    settle();

    // 2x2 bins over 5 ticks by 4 wires; scale write carries junk in its upper bits
    program_pool(14'h3F82, 14'd2, 14'd5, 14'd4);
    queue_sample(16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
    queue_sample(-16'sd1, 16'sd100, 1'b1, 1'b1);
    queue_sample(16'sd5, 16'sd7, 1'b0, 1'b1);
    queue_sample(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
    queue_sample(16'sd1000, 16'sd1000, 1'b1, 1'b1);
    queue_sample(16'sd10, 16'sd20, 1'b1, 1'b1);
    queue_sample(16'sd0, 16'sd0, 1'b0, 1'b0);
    queue_sample(-16'sd5, -16'sd5, 1'b1, 1'b1);
    queue_sample(16'sd3, 16'sh7FFF, 1'b1, 1'b1);
    queue_sample(-16'sd1, -16'sd1, 1'b1, 1'b1);
    repeat (5) queue_sample(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
    repeat (5) queue_sample(16'sh8000, 16'sh8000, 1'b1, 1'b1);
    repeat (2) queue_sample(16'sd7, 16'sd9, 1'b1, 1'b1);
    settle();

    // every sample is its own bin, ticks wrap onto the next wire
    run_phase(14'd1, 14'd1, 14'd7, 14'd5, 12, IDLE_NONE, 1'b0);
    run_phase(14'd3, 14'd2, 14'd10, 14'd7, 20, IDLE_SENDER, 1'b0);
    // zero scale, widest row group, trailing partial row
    run_phase(14'd0, 14'd64, 14'd1, 14'd65, 65, IDLE_RECEIVER, 1'b0);
    // scale above the limit, zero row scale, partial bins
    run_phase(14'd127, 14'd0, 14'd66, 14'd2, 66, IDLE_BOTH, 1'b0);
    // zero sizes with the widest bins: no full bin ever
    run_phase(14'd64, 14'd127, 14'd0, 14'd0, 8, IDLE_NONE, 1'b0);
    // zero sizes, unit scales: every sample ends the image
    run_phase(14'd1, 14'd1, 14'd0, 14'd0, 10, IDLE_SENDER, 1'b0);
    // largest sizes, bins run past the line buffer, long receiver hold-off
    run_phase(14'd1, 14'd1, 14'd16383, 14'd16383, 1028, IDLE_NONE, 1'b1);
    // random small geometries
    for (int p = 0; p < 3; p++) begin
      run_phase(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 4)),
                CFG_DATA_W'($urandom_range(1, 24)), CFG_DATA_W'($urandom_range(1, 10)),
                $urandom_range(6, 10), idle_mode_e'((p + 1) % 4), 1'b0);
    end

    settle();
    $display("%0d samples over %0d register settings, %0d pooled results checked",
             samples_taken, settings_run, results_checked);
    $display("covered scale clamping, zero sizes, partial groups, bins past the buffer, stalls");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
